// File: hw/rtl/wlba_pkg.sv
// Shared constants, types and controller/datapath interface structs of the wear-leveling allocator
package wlba_pkg;

	localparam int NUM_BLOCKS   = 16;
	localparam int BLOCK_BYTES  = 4096;
	localparam int IDX_W        = $clog2(NUM_BLOCKS);
	localparam int SIZE_W       = 20;
	localparam int COUNT_W      = 8;
	localparam int BLK_W        = 4;
	localparam int CHUNK_W      = 5;
	localparam int THR_RESET    = 100;
	localparam longint CAPACITY = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);

	typedef enum logic [1:0] {
		KIND_ERASE = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GC,
		ST_SCAN,
		ST_ALLOC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic gc;
		logic scan;
		logic alloc;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic no_chunks;
		logic chunk_last;
	} sts_t;

endpackage

// File: hw/rtl/wlba_ctrl.sv
// Sequencer for garbage collection, least-worn scans, allocations and the done result
module wlba_ctrl import wlba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_GC;
				end
			end
			ST_GC: begin
				if (sts.idx_last) begin
					state_d = sts.no_chunks ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.idx_last) begin
					state_d = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				state_d = sts.chunk_last ? ST_DONE : ST_SCAN;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd   = '0;
		busy  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_GC: begin
				cmd.gc = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_ALLOC: begin
				cmd.alloc = 1'b1;
			end
			ST_DONE: begin
				cmd.done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// File: hw/rtl/wlba_dp.sv
// Datapath: wear count registers, threshold, scan index, least-worn tracking and result register
module wlba_dp import wlba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [SIZE_W-1:0]    size_bytes,
	input  logic                 cfg_we,
	input  logic [COUNT_W-1:0]   cfg_data,
	output logic                 result_valid,
	output logic [1:0]           kind,
	output logic [BLK_W-1:0]     block_index,
	output logic [CHUNK_W-1:0]   chunk_index,
	output logic                 too_large,
	output logic                 last
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BLOCKS - 1);

	logic [COUNT_W-1:0] wear_q [NUM_BLOCKS];
	logic [COUNT_W-1:0] thr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [COUNT_W-1:0] best_cnt_q;
	logic [CHUNK_W-1:0] chunks_q;
	logic [CHUNK_W-1:0] chunk_cnt_q;
	logic               big_q;
	logic               valid_q;
	kind_t              kind_q;
	logic [BLK_W-1:0]   blk_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic               big_out_q;
	logic               last_q;

	logic [COUNT_W-1:0] rd_cnt;
	logic               over;
	logic               size_big;
	logic [63:0]        size_cl;
	logic [63:0]        chunks_full;
	logic [COUNT_W-1:0] best_inc;

	assign rd_cnt      = wear_q[idx_q];
	assign over        = rd_cnt > thr_q;
	assign size_big    = {44'd0, size_bytes} > 64'(CAPACITY);
	assign size_cl     = size_big ? 64'(CAPACITY) : {44'd0, size_bytes};
	assign chunks_full = (size_cl + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
	assign best_inc    = (best_cnt_q == '1) ? best_cnt_q : best_cnt_q + COUNT_W'(1);

	assign sts.idx_last   = idx_q == IDX_LAST;
	assign sts.no_chunks  = chunks_q == '0;
	assign sts.chunk_last = (chunk_cnt_q + CHUNK_W'(1)) == chunks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= COUNT_W'(THR_RESET);
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				wear_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				if (cmd.gc && over && idx_q == IDX_W'(i)) begin
					wear_q[i] <= '0;
				end else if (cmd.alloc && best_idx_q == IDX_W'(i)) begin
					wear_q[i] <= best_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			chunk_cnt_q <= '0;
		end else if (cmd.load) begin
			idx_q       <= '0;
			chunk_cnt_q <= '0;
		end else begin
			if (cmd.gc || cmd.scan) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
			end
			if (cmd.alloc) begin
				chunk_cnt_q <= chunk_cnt_q + CHUNK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			chunks_q <= chunks_full[CHUNK_W-1:0];
			big_q    <= size_big;
		end
		if (cmd.scan) begin
			if (idx_q == '0 || rd_cnt < best_cnt_q) begin
				best_idx_q <= idx_q;
				best_cnt_q <= rd_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (cmd.gc && over) || cmd.alloc || cmd.done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gc) begin
			kind_q    <= KIND_ERASE;
			blk_q     <= BLK_W'(idx_q);
			chunk_q   <= '0;
			big_out_q <= 1'b0;
			last_q    <= 1'b0;
		end else if (cmd.alloc) begin
			kind_q    <= KIND_ALLOC;
			blk_q     <= BLK_W'(best_idx_q);
			chunk_q   <= chunk_cnt_q;
			big_out_q <= 1'b0;
			last_q    <= 1'b0;
		end else if (cmd.done) begin
			kind_q    <= KIND_DONE;
			blk_q     <= '0;
			chunk_q   <= chunks_q;
			big_out_q <= big_q;
			last_q    <= 1'b1;
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign block_index  = blk_q;
	assign chunk_index  = chunk_q;
	assign too_large    = big_out_q;
	assign last         = last_q;

endmodule

// File: hw/rtl/wear_leveling_block_allocator.sv
// Top level of the least-worn block wear-leveling allocator
// A request runs garbage collection over all counts, then a scan and an allocation per chunk, then the done result.
// A new request is taken only once the last one is done and busy is low; each step reads one wear count per cycle.
// Garbage collection reads every count once; each chunk rescans all 16 counts.
// Reset clears all wear counts, sets the erase threshold to 100 and returns to idle.
// Results are strobed for one cycle each; the receiver cannot stall.
module wear_leveling_block_allocator import wlba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [SIZE_W-1:0]    size_bytes,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [COUNT_W-1:0]   cfg_data,
	output logic                 result_valid,
	output logic [1:0]           kind,
	output logic [BLK_W-1:0]     block_index,
	output logic [CHUNK_W-1:0]   chunk_index,
	output logic                 too_large,
	output logic                 last
);

	cmd_t cmd;
	sts_t sts;
	logic busy_w;

	wlba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy_w)
	);

	wlba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.size_bytes   (size_bytes),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.kind         (kind),
		.block_index  (block_index),
		.chunk_index  (chunk_index),
		.too_large    (too_large),
		.last         (last)
	);

	assign busy      = busy_w;
	assign cfg_ready = !busy_w;

	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> kind == KIND_DONE)
		else $error("last set on a result that is not done");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_DONE |-> !busy)
		else $error("still busy when done result is out");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != KIND_DONE |-> $past(busy))
		else $error("erase or allocation result outside a run");

endmodule
